// ===== design/perlin_noise_3d_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PERLIN_NOISE_3D_CORE_ASSERT_SVH
`define PERLIN_NOISE_3D_CORE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define PN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define PN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/pn3d_pkg.sv =====
package pn3d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 24;
  localparam int INT_BITS   = COORD_W - FRAC_BITS;
  localparam int OUT_W      = 16;
  // Signed working width for fractions, dots and interpolants.
  localparam int VAL_W      = FRAC_BITS + 4;
  localparam int PIPE_DEPTH = 12;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [7:0] idx_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,
    8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
    8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,
    8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,
    8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,
    8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,
    8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,
    8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,
    8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,
    8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
    8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,
    8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,
    8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,
    8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_at(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  // Gradient dot product for one corner.
  function automatic val_t dot_grad(input logic [3:0] h, input val_t dx,
                                    input val_t dy, input val_t dz);
    val_t s;
    val_t t;
    s = (h < 4'd8) ? dx : dy;
    if (h < 4'd4) t = dy;
    else if (h == 4'd12 || h == 4'd14) t = dx;
    else t = dz;
    return (h[0] ? -s : s) + (h[1] ? -t : t);
  endfunction

endpackage

// ===== design/pn3d_lerp.sv =====
// Registered lerp a + floor((b-a)*w / 2^F); the product and then the sum are registered.
module pn3d_lerp (
  input  logic            clk,
  input  pn3d_pkg::val_t  a,
  input  pn3d_pkg::val_t  b,
  input  pn3d_pkg::frac_t w,
  output pn3d_pkg::val_t  y
);
  import pn3d_pkg::*;

  localparam int PW = VAL_W + FRAC_BITS + 2;

  logic signed [PW-1:0] prod;
  val_t a_q;
  logic signed [VAL_W:0] diff;

  assign diff = {a[VAL_W-1], a};
  always_ff @(posedge clk) begin
    prod <= ($signed({b[VAL_W-1], b}) - $signed(diff)) * $signed({1'b0, w});
    a_q  <= a;
  end
  // Arithmetic shift floors toward minus infinity.
  always_ff @(posedge clk) begin
    y <= a_q + val_t'(prod >>> FRAC_BITS);
  end
endmodule

// ===== design/perlin_noise_3d_core.sv =====
// Improved 3D Perlin noise core.
// Input: pulse start with coord_x, coord_y, coord_z (8.16 unsigned) while
// busy is low; busy is tied low, so a word is taken every cycle.
// Output: noise_value, (n+1)/2 in unsigned 0.16, shown for one cycle with
// valid high. The receiver cannot stall; every word must be taken when shown.
// A start pulse travels down the vld shift register beside its word;
// throughput is one word per clock.
// The pipeline depth is set by the chain of three permutation lookups, the fade
// polynomial (three multiplies) and three levels of registered lerps.
// The permutation table is a constant ROM read in the same cycle per stage.
// Reset clears the valid pipeline only; words in flight are dropped.
module perlin_noise_3d_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pn3d_pkg::COORD_W-1:0]  coord_x,
  input  logic [pn3d_pkg::COORD_W-1:0]  coord_y,
  input  logic [pn3d_pkg::COORD_W-1:0]  coord_z,
  output logic                          valid,
  output logic [pn3d_pkg::OUT_W-1:0]    noise_value
);
  import pn3d_pkg::*;

  localparam val_t ONE = val_t'(1) <<< FRAC_BITS;

  logic [PIPE_DEPTH-1:0] vld;

  // Stage 1: first hash level and fade squares.
  frac_t fx1, fy1, fz1;
  logic [7:0] a1, b1, zi1;
  logic [2*FRAC_BITS-1:0] sqx, sqy, sqz;
  // Stage 2: second hash level, cubes.
  frac_t fx2, fy2, fz2;
  logic [7:0] aa2, ab2, ba2, bb2;
  frac_t t2x, t2y, t2z;
  logic [2*FRAC_BITS-1:0] cbx, cby, cbz;
  // Stage 3: corner hashes, fade cubic and quintic factor.
  frac_t fx3, fy3, fz3;
  logic [3:0] h3 [8];
  frac_t t3x, t3y, t3z;
  logic [FRAC_BITS+4:0] qx3, qy3, qz3;
  // Stage 4: dots and fade product.
  val_t d4 [8];
  logic [2*FRAC_BITS+4:0] fpx, fpy, fpz;
  // Fade weights valid from stage 5 on, delayed to match lerp levels.
  frac_t wu5, wv5, ww5, wv6, wv7, ww6, ww7, ww8, ww9;
  val_t l [4];
  val_t m [2];
  val_t n;
  logic signed [VAL_W:0] v_s;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[PIPE_DEPTH-2:0], start};
  end

  always_ff @(posedge clk) begin
    fx1 <= coord_x[FRAC_BITS-1:0];
    fy1 <= coord_y[FRAC_BITS-1:0];
    fz1 <= coord_z[FRAC_BITS-1:0];
    a1  <= perm_at(coord_x[COORD_W-1:FRAC_BITS]) + coord_y[COORD_W-1:FRAC_BITS];
    b1  <= perm_at(coord_x[COORD_W-1:FRAC_BITS] + 8'd1) + coord_y[COORD_W-1:FRAC_BITS];
    zi1 <= coord_z[COORD_W-1:FRAC_BITS];
    sqx <= coord_x[FRAC_BITS-1:0] * coord_x[FRAC_BITS-1:0];
    sqy <= coord_y[FRAC_BITS-1:0] * coord_y[FRAC_BITS-1:0];
    sqz <= coord_z[FRAC_BITS-1:0] * coord_z[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    fx2 <= fx1; fy2 <= fy1; fz2 <= fz1;
    aa2 <= perm_at(a1) + zi1;
    ab2 <= perm_at(a1 + 8'd1) + zi1;
    ba2 <= perm_at(b1) + zi1;
    bb2 <= perm_at(b1 + 8'd1) + zi1;
    t2x <= sqx[2*FRAC_BITS-1:FRAC_BITS];
    t2y <= sqy[2*FRAC_BITS-1:FRAC_BITS];
    t2z <= sqz[2*FRAC_BITS-1:FRAC_BITS];
    cbx <= sqx[2*FRAC_BITS-1:FRAC_BITS] * fx1;
    cby <= sqy[2*FRAC_BITS-1:FRAC_BITS] * fy1;
    cbz <= sqz[2*FRAC_BITS-1:FRAC_BITS] * fz1;
  end

  // q = 10 - 15t + 6t^2, always positive and below 16.
  function automatic logic [FRAC_BITS+4:0] qpoly(input frac_t t, input frac_t t2);
    logic [FRAC_BITS+5:0] acc;
    acc = (22'(10) << FRAC_BITS) + 22'(t2) * 22'd6 - 22'(t) * 22'd15;
    return acc[FRAC_BITS+4:0];
  endfunction

  // Gradient code: low four bits of the hashed corner.
  function automatic logic [3:0] grad_code(input logic [7:0] idx);
    logic [7:0] p;
    p = perm_at(idx);
    return p[3:0];
  endfunction

  always_ff @(posedge clk) begin
    fx3 <= fx2; fy3 <= fy2; fz3 <= fz2;
    h3[0] <= grad_code(aa2);
    h3[1] <= grad_code(ba2);
    h3[2] <= grad_code(ab2);
    h3[3] <= grad_code(bb2);
    h3[4] <= grad_code(aa2 + 8'd1);
    h3[5] <= grad_code(ba2 + 8'd1);
    h3[6] <= grad_code(ab2 + 8'd1);
    h3[7] <= grad_code(bb2 + 8'd1);
    t3x <= cbx[2*FRAC_BITS-1:FRAC_BITS];
    t3y <= cby[2*FRAC_BITS-1:FRAC_BITS];
    t3z <= cbz[2*FRAC_BITS-1:FRAC_BITS];
    qx3 <= qpoly(fx2, t2x);
    qy3 <= qpoly(fy2, t2y);
    qz3 <= qpoly(fz2, t2z);
  end

  // Corner offsets: index bit 0 selects x, bit 1 y, bit 2 z.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) begin
      d4[c] <= dot_grad(h3[c],
                        c[0] ? val_t'(fx3) - ONE : val_t'(fx3),
                        c[1] ? val_t'(fy3) - ONE : val_t'(fy3),
                        c[2] ? val_t'(fz3) - ONE : val_t'(fz3));
    end
    fpx <= t3x * qx3;
    fpy <= t3y * qy3;
    fpz <= t3z * qz3;
  end

  // The later weights are delayed to match the registered lerp levels: wv6, wv7 and ww6 to ww9.
  always_ff @(posedge clk) begin
    wu5 <= fpx[2*FRAC_BITS-1:FRAC_BITS];
    wv5 <= fpy[2*FRAC_BITS-1:FRAC_BITS];
    ww5 <= fpz[2*FRAC_BITS-1:FRAC_BITS];
    wv6 <= wv5;  wv7 <= wv6;
    ww6 <= ww5;  ww7 <= ww6;  ww8 <= ww7;  ww9 <= ww8;
  end

  // Weight wu5 is registered from the fade product, so the dots are held in d5 to match it.
  val_t d5 [8];
  always_ff @(posedge clk) d5 <= d4;

  for (genvar i = 0; i < 4; i++) begin : g_l1
    pn3d_lerp u_l (.clk(clk), .a(d5[2*i]), .b(d5[2*i+1]), .w(wu5), .y(l[i]));
  end
  for (genvar j = 0; j < 2; j++) begin : g_l2
    pn3d_lerp u_m (.clk(clk), .a(l[2*j]), .b(l[2*j+1]), .w(wv7), .y(m[j]));
  end
  pn3d_lerp u_n (.clk(clk), .a(m[0]), .b(m[1]), .w(ww9), .y(n));

  // Output: floor((n+1)/2) in 0.16, saturated.
  assign v_s = {n[VAL_W-1], n} + {1'b0, ONE};
  always_ff @(posedge clk) begin
    if (v_s <= 0) noise_value <= '0;
    else if (v_s[VAL_W:FRAC_BITS+1] != '0) noise_value <= '1;
    else noise_value <= v_s[FRAC_BITS:FRAC_BITS+1-OUT_W];
  end

  assign valid = vld[PIPE_DEPTH-1];
endmodule

// ===== design/perlin_noise_3d_core_checker.sv =====
`include "perlin_noise_3d_core_assert.svh"
module perlin_noise_3d_core_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic valid
);
  import pn3d_pkg::*;

  `PN_ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy)
  `PN_ASSERT_IMPL(a_valid_follows, clk, rst,
    valid && !$past(rst, PIPE_DEPTH), $past(start, PIPE_DEPTH))
  `PN_ASSERT_IMPL(a_no_spurious, clk, rst,
    !$past(start, PIPE_DEPTH) && !$past(rst, PIPE_DEPTH), !valid)
  `PN_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !valid)
endmodule

bind perlin_noise_3d_core perlin_noise_3d_core_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .valid(valid)
);
